FILE: design/spag_pkg.sv
// Shared types and constants for the sprite pixel address generator.
// No dependencies; imported by spag_affine and sprite_pixel_address_generator.
`default_nettype none

package spag_pkg;

	// Configuration register indexes
	localparam logic CFG_ENGINE_SELECT = 1'b0;
	localparam logic CFG_ONE_D_MAPPING = 1'b1;

	// Tile data windows of the two engines
	localparam logic [14:0] WIN_MASK_MAIN = 15'h7FFF;
	localparam logic [14:0] WIN_MASK_SUB  = 15'h3FFF;

	// Sprite size in pixels
	typedef struct packed {
		logic [6:0] w;
		logic [6:0] h;
	} sprite_dim_t;

	// Per-sprite data that rides along the affine stages
	typedef struct packed {
		logic       keep;     // enabled and inside the (double-size) box
		logic       rot;
		logic [6:0] w;
		logic [6:0] h;
		logic       bpp8;
		logic [5:0] px;       // texel column for non-rotated sprites
		logic [5:0] py;       // texel row for non-rotated sprites
		logic [9:0] tile;
		logic [3:0] pal;
		logic [1:0] prio;
	} spag_meta_t;

	// Decode shape and size; the reserved shape is treated as square
	function automatic sprite_dim_t dim_lookup(input logic [1:0] shape, input logic [1:0] size);
		sprite_dim_t d;
		d.w = 7'd8;
		d.h = 7'd8;
		case (shape)
			2'd1: begin
				case (size)
					2'd0: begin d.w = 7'd16; d.h = 7'd8;  end
					2'd1: begin d.w = 7'd32; d.h = 7'd8;  end
					2'd2: begin d.w = 7'd32; d.h = 7'd16; end
					default: begin d.w = 7'd64; d.h = 7'd32; end
				endcase
			end
			2'd2: begin
				case (size)
					2'd0: begin d.w = 7'd8;  d.h = 7'd16; end
					2'd1: begin d.w = 7'd8;  d.h = 7'd32; end
					2'd2: begin d.w = 7'd16; d.h = 7'd32; end
					default: begin d.w = 7'd32; d.h = 7'd64; end
				endcase
			end
			default: begin
				case (size)
					2'd0: begin d.w = 7'd8;  d.h = 7'd8;  end
					2'd1: begin d.w = 7'd16; d.h = 7'd16; end
					2'd2: begin d.w = 7'd32; d.h = 7'd32; end
					default: begin d.w = 7'd64; d.h = 7'd64; end
				endcase
			end
		endcase
		return d;
	endfunction

endpackage

`default_nettype wire

FILE: design/spag_affine.sv
// Two-stage 8.8 affine transform: products in stage 2, floored sums in stage 3.
// Imports spag_pkg; no other dependencies.
`default_nettype none

module spag_affine
	import spag_pkg::*;
(
	input  wire logic               clk,
	input  wire logic signed [8:0]  rx_s1,
	input  wire logic signed [8:0]  ry_s1,
	input  wire logic signed [15:0] pa_s1,
	input  wire logic signed [15:0] pb_s1,
	input  wire logic signed [15:0] pc_s1,
	input  wire logic signed [15:0] pd_s1,
	output logic signed [17:0]      fx_s3,
	output logic signed [17:0]      fy_s3
);

	logic signed [24:0] pa_rx_s2, pb_ry_s2, pc_rx_s2, pd_ry_s2;
	logic signed [25:0] sum_x, sum_y;

	// Form the four products
	always_ff @(posedge clk) begin
		pa_rx_s2 <= pa_s1 * rx_s1;
		pb_ry_s2 <= pb_s1 * ry_s1;
		pc_rx_s2 <= pc_s1 * rx_s1;
		pd_ry_s2 <= pd_s1 * ry_s1;
	end

	// Add pairs; dropping the low byte floors toward minus infinity
	assign sum_x = {pa_rx_s2[24], pa_rx_s2} + {pb_ry_s2[24], pb_ry_s2};
	assign sum_y = {pc_rx_s2[24], pc_rx_s2} + {pd_ry_s2[24], pd_ry_s2};

	always_ff @(posedge clk) begin
		fx_s3 <= sum_x[25:8];
		fy_s3 <= sum_y[25:8];
	end

endmodule

`default_nettype wire

FILE: design/sprite_pixel_address_generator.sv
// Top level of the sprite pixel address generator: decode, affine, address stages.
// Depends on spag_pkg and spag_affine.
//
// Usage:
//   Input: present screen_x/screen_y, the three attribute words and the four
//   affine parameters with start high; busy is always low, so a transfer
//   happens at every clock edge where start is high.
//   Output: each transfer yields exactly one result, driven with done high
//   once it has passed the five register stages (decode, multiply, sum,
//   range check, address). A new item may be started every cycle, so
//   throughput is one item per clock.
//   The receiver cannot stall; results are never held back.
//   Configuration: cfg_valid/cfg_ready write channel, cfg_ready always high;
//   cfg_index 0 selects engine_select, 1 selects one_d_mapping, bit 0 of
//   cfg_data is the value. Write only when no results are outstanding.
//   Reset (arst_n low) clears both registers and all pipeline valid bits.
//   A result that is not visible has every field zero.
`default_nettype none

module sprite_pixel_address_generator
	import spag_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [7:0]  screen_x,
	input  wire logic [7:0]  screen_y,
	input  wire logic [15:0] attr_word0,
	input  wire logic [15:0] attr_word1,
	input  wire logic [15:0] attr_word2,
	input  wire logic signed [15:0] param_a,
	input  wire logic signed [15:0] param_b,
	input  wire logic signed [15:0] param_c,
	input  wire logic signed [15:0] param_d,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic        cfg_data,
	output logic             done,
	output logic             visible,
	output logic [14:0]      byte_address,
	output logic             full_byte,
	output logic             high_nibble,
	output logic [3:0]       palette_row,
	output logic [1:0]       priority_res
);

	logic engine_select_q, one_d_mapping_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			engine_select_q <= 1'b0;
			one_d_mapping_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_ENGINE_SELECT: engine_select_q <= cfg_data;
				CFG_ONE_D_MAPPING: one_d_mapping_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------- Stage 1: decode and box test ----------------
	sprite_dim_t dim;
	logic        rot, dbl_bit, dbl, disabled, in_box;
	logic [5:0]  half_w, half_h;
	logic [8:0]  dx;
	logic [7:0]  dy, dw, dh;
	logic [5:0]  flip_px, flip_py;
	spag_meta_t  meta_d;

	assign dim      = dim_lookup(attr_word0[15:14], attr_word1[15:14]);
	assign rot      = attr_word0[8];
	assign dbl_bit  = attr_word0[9];
	assign dbl      = rot & dbl_bit;
	assign disabled = attr_word0[11] | (~rot & dbl_bit);
	assign half_w   = dim.w[6:1];
	assign half_h   = dim.h[6:1];

	// Offsets from the sprite origin, wrapped to 512 by 256
	assign dx = {1'b0, screen_x} - attr_word1[8:0] + (dbl ? {3'b0, half_w} : 9'd0);
	assign dy = screen_y - attr_word0[7:0] + (dbl ? {2'b0, half_h} : 8'd0);
	assign dw = dbl ? {dim.w, 1'b0} : {1'b0, dim.w};
	assign dh = dbl ? {dim.h, 1'b0} : {1'b0, dim.h};
	assign in_box = (dx < {1'b0, dw}) && (dy < dh);

	// Flipped texel position for non-rotated sprites (wraps correctly at 64)
	assign flip_px = attr_word1[12] ? (dim.w[5:0] - 6'd1 - dx[5:0]) : dx[5:0];
	assign flip_py = attr_word1[13] ? (dim.h[5:0] - 6'd1 - dy[5:0]) : dy[5:0];

	always_comb begin
		meta_d.keep = ~disabled & in_box;
		meta_d.rot  = rot;
		meta_d.w    = dim.w;
		meta_d.h    = dim.h;
		meta_d.bpp8 = attr_word0[13];
		meta_d.px   = flip_px;
		meta_d.py   = flip_py;
		meta_d.tile = attr_word2[9:0];
		meta_d.pal  = attr_word2[15:12];
		meta_d.prio = attr_word2[11:10];
	end

	logic              v_s1, v_s2, v_s3, v_s4;
	spag_meta_t        meta_s1, meta_s2, meta_s3;
	logic signed [8:0] rx_s1, ry_s1;
	logic signed [15:0] pa_s1, pb_s1, pc_s1, pd_s1;

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			done <= 1'b0;
		end else begin
			v_s1 <= start & ~busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			done <= v_s4;
		end
	end

	// Stage 1 payload: centred coordinates and parameters
	always_ff @(posedge clk) begin
		meta_s1 <= meta_d;
		rx_s1   <= $signed(dx - {3'b0, half_w});
		ry_s1   <= $signed({1'b0, dy} - {3'b0, half_h});
		pa_s1   <= param_a;
		pb_s1   <= param_b;
		pc_s1   <= param_c;
		pd_s1   <= param_d;
	end

	// ---------------- Stages 2 and 3: affine transform ----------------
	logic signed [17:0] fx_s3, fy_s3;

	spag_affine u_affine (
		.clk   (clk),
		.rx_s1 (rx_s1),
		.ry_s1 (ry_s1),
		.pa_s1 (pa_s1),
		.pb_s1 (pb_s1),
		.pc_s1 (pc_s1),
		.pd_s1 (pd_s1),
		.fx_s3 (fx_s3),
		.fy_s3 (fy_s3)
	);

	always_ff @(posedge clk) begin
		meta_s2 <= meta_s1;
		meta_s3 <= meta_s2;
	end

	// ---------------- Stage 4: recentre and range check ----------------
	logic signed [17:0] fx, fy;
	logic               fx_ok, fy_ok;

	assign fx    = fx_s3 + $signed({12'b0, meta_s3.w[6:1]});
	assign fy    = fy_s3 + $signed({12'b0, meta_s3.h[6:1]});
	assign fx_ok = ~fx[17] && (fx[16:0] < {10'b0, meta_s3.w});
	assign fy_ok = ~fy[17] && (fy[16:0] < {10'b0, meta_s3.h});

	logic       vis_s4, bpp8_s4;
	logic [5:0] px_s4, py_s4;
	logic [6:0] w_s4;
	logic [9:0] tile_s4;
	logic [3:0] pal_s4;
	logic [1:0] prio_s4;

	always_ff @(posedge clk) begin
		vis_s4  <= meta_s3.keep & (~meta_s3.rot | (fx_ok & fy_ok));
		px_s4   <= meta_s3.rot ? fx[5:0] : meta_s3.px;
		py_s4   <= meta_s3.rot ? fy[5:0] : meta_s3.py;
		w_s4    <= meta_s3.w;
		bpp8_s4 <= meta_s3.bpp8;
		tile_s4 <= meta_s3.tile;
		pal_s4  <= meta_s3.pal;
		prio_s4 <= meta_s3.prio;
	end

	// ---------------- Stage 5: tile address ----------------
	logic [2:0]  tx, ty;
	logic [6:0]  idx1;
	logic [14:0] base1, base2, addr;
	logic [5:0]  row;
	logic [8:0]  ty_row;
	logic [8:0]  idx2;
	logic [9:0]  step2;
	logic [5:0]  offset;

	assign tx = px_s4[5:3];
	assign ty = py_s4[5:3];

	// One-dimensional: tiles of a sprite are consecutive
	assign idx1  = 7'(ty * w_s4[6:3]) + {4'b0, tx};
	assign base1 = {tile_s4, 5'b0} +
		(bpp8_s4 ? {2'b0, idx1, 6'b0} : {3'b0, idx1, 5'b0});

	// Two-dimensional: fixed row pitch in tile numbers
	always_comb begin
		case ({engine_select_q, bpp8_s4})
			2'b00:   row = 6'd32;
			2'b01:   row = 6'd16;
			2'b10:   row = 6'd16;
			default: row = 6'd8;
		endcase
	end
	assign ty_row = 9'(ty * row);
	assign idx2   = ty_row + {6'b0, tx};
	assign step2  = bpp8_s4 ? {idx2, 1'b0} : {1'b0, idx2};
	assign base2  = 15'(({5'b0, tile_s4} + {5'b0, step2}) << 5);

	assign offset = bpp8_s4 ? {py_s4[2:0], px_s4[2:0]} : {1'b0, py_s4[2:0], px_s4[2:1]};
	assign addr   = ((one_d_mapping_q ? base1 : base2) + {9'b0, offset}) &
		(engine_select_q ? WIN_MASK_SUB : WIN_MASK_MAIN);

	// Hold result fields for the strobe cycle; zero them when not visible
	always_ff @(posedge clk) begin
		visible      <= vis_s4;
		byte_address <= vis_s4 ? addr : 15'd0;
		full_byte    <= vis_s4 & bpp8_s4;
		high_nibble  <= vis_s4 & ~bpp8_s4 & px_s4[0];
		palette_row  <= vis_s4 ? pal_s4 : 4'd0;
		priority_res <= vis_s4 ? prio_s4 : 2'd0;
	end

endmodule

`default_nettype wire
